FILE: hdl/diff_drive_encoder_odometry_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the odometry unit
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ENCODER_ODOMETRY_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ENCODER_ODOMETRY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DDO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DDO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and helper functions of the wheel odometry unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MPC   = 2'd0;
    localparam logic [1:0] CFG_TPCD  = 2'd1;
    localparam logic [1:0] CFG_GUARD = 2'd2;

    localparam logic [31:0] MPC_RESET  = 32'd3091146;
    localparam logic [31:0] TPCD_RESET = 32'd491974;
    localparam logic [31:0] MEGA       = 32'd1000000;

    // Sequencer steps
    localparam logic [3:0] STP_LMAG = 4'd0;
    localparam logic [3:0] STP_LNUM = 4'd1;
    localparam logic [3:0] STP_LDIV = 4'd2;
    localparam logic [3:0] STP_RMAG = 4'd3;
    localparam logic [3:0] STP_RNUM = 4'd4;
    localparam logic [3:0] STP_RDIV = 4'd5;
    localparam logic [3:0] STP_AMAG = 4'd6;
    localparam logic [3:0] STP_ANUM = 4'd7;
    localparam logic [3:0] STP_ADIV = 4'd8;
    localparam logic [3:0] STP_HDEL = 4'd9;
    localparam logic [3:0] STP_DIST = 4'd10;
    localparam logic [3:0] STP_COR1 = 4'd11;
    localparam logic [3:0] STP_MOVX = 4'd12;
    localparam logic [3:0] STP_MOVY = 4'd13;
    localparam logic [3:0] STP_COR2 = 4'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_MUL,
        K_DIV,
        K_COR
    } t_kind;

    // Unit start strobes from the sequencer
    typedef struct packed {
        logic mul;
        logic div;
        logic cor;
    } t_start;

    function automatic t_kind f_step_kind(input logic [3:0] step);
        t_kind k;
        unique case (step)
            STP_LDIV, STP_RDIV, STP_ADIV: k = K_DIV;
            STP_COR1, STP_COR2:           k = K_COR;
            default:                      k = K_MUL;
        endcase
        return k;
    endfunction

    // Arctangent of 2^-i as binary angle
    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Signed saturation of a clamped quotient
    function automatic logic [31:0] f_sat_speed(input logic [32:0] q, input logic neg);
        logic [31:0] v;
        if (neg) begin
            v = (q >= 33'h080000000) ? 32'h80000000 : (32'd0 - q[31:0]);
        end else begin
            v = (q >= 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        end
        return v;
    endfunction

    function automatic logic [32:0] f_abs33(input logic [32:0] v);
        return v[32] ? (33'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Shared 64x32 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [95:0]      o_prod
);
    logic [1:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_a_hi;
    logic [31:0] r_b;
    logic [63:0] r_p0;
    logic [63:0] r_p1;
    logic [95:0] r_prod;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 2'd1;
            end else if (r_cnt == 2'd1) begin
                r_cnt <= 2'd2;
            end else if (r_cnt == 2'd2) begin
                r_cnt  <= 2'd0;
                r_done <= 1'b1;
            end
        end
    end

    // Low half, high half, then combine
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a_hi <= i_a[63:32];
            r_b    <= i_b;
            r_p0   <= 64'(i_a[31:0]) * 64'(i_b);
        end
        if (r_cnt == 2'd1) begin
            r_p1 <= 64'(r_a_hi) * 64'(r_b);
        end
        if (r_cnt == 2'd2) begin
            r_prod <= {r_p1, 32'd0} + {32'd0, r_p0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

`default_nettype wire

FILE: hdl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle, quotient clamped at 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [67:0] i_num,
    input  wire logic [23:0] i_den,
    output logic             o_done,
    output logic [32:0]      o_quot
);
    localparam int NB = 68;

    logic [6:0]  r_cnt;
    logic        r_done;
    logic [67:0] r_num;
    logic [23:0] r_den;
    logic [24:0] r_rem;
    logic [32:0] r_quot;

    logic [24:0] n_rem;
    logic [32:0] n_quot;
    logic        sub_ok;
    logic [24:0] shifted;

    // One restoring step
    always_comb begin
        shifted = {r_rem[23:0], r_num[67]};
        sub_ok  = shifted >= {1'b0, r_den};
        n_rem   = sub_ok ? (shifted - {1'b0, r_den}) : shifted;
        if (r_quot[32] || r_quot[31]) begin
            n_quot = 33'h100000000;
        end else begin
            n_quot = {r_quot[31:0], sub_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 7'(NB);
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= 25'd0;
            r_quot <= 33'd0;
        end else if (r_cnt != 7'd0) begin
            r_num  <= {r_num[66:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

`default_nettype wire

FILE: hdl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC rotation giving clamped Q1.30 cosine and sine.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_angle,
    output logic             o_done,
    output logic [31:0]      o_cos,
    output logic [31:0]      o_sin
);
    import ddo_pkg::*;

    localparam int IW = $clog2(STEPS);
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] X_INIT  = 34'sd652032874;

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_i;
    logic          r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;

    logic signed [33:0] z0;
    logic signed [33:0] zf;
    logic               flip0;
    logic signed [33:0] atan_s;
    logic signed [33:0] xo;
    logic signed [33:0] yo;

    // Fold the start angle into the right half plane
    always_comb begin
        z0    = 34'(signed'(i_angle));
        zf    = z0;
        flip0 = 1'b0;
        if (z0 > QUARTER) begin
            zf    = z0 - (QUARTER <<< 1);
            flip0 = 1'b1;
        end else if (z0 < -QUARTER) begin
            zf    = z0 + (QUARTER <<< 1);
            flip0 = 1'b1;
        end
        atan_s = signed'({2'b00, f_atan(5'(r_i))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == IW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Rotate one micro-step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= X_INIT;
            r_y    <= 34'sd0;
            r_z    <= zf;
            r_flip <= flip0;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + IW'(1);
            if (!r_z[33]) begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - atan_s;
            end else begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + atan_s;
            end
        end
    end

    // Undo the fold and clamp
    always_comb begin
        xo = r_flip ? -r_x : r_x;
        yo = r_flip ? -r_y : r_y;
        if (xo > QUARTER)  xo = QUARTER;
        if (xo < -QUARTER) xo = -QUARTER;
        if (yo > QUARTER)  yo = QUARTER;
        if (yo < -QUARTER) yo = -QUARTER;
    end

    assign o_done = r_done;
    assign o_cos  = xo[31:0];
    assign o_sin  = yo[31:0];
endmodule

`default_nettype wire

FILE: hdl/diff_drive_encoder_odometry_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_encoder_odometry_unit
// Differential-drive wheel odometry: speeds, planar pose and heading quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes {elapsed_us, right_count, left_count}; master stream
//   gives the pose, quaternion and speeds, with time_fault on tuser.
//   The first transaction after reset only stores the counts, no result.
//   Each later transaction runs 15 steps on three shared units: a 64x32
//   multiplier (10 steps), a bit-serial divider (3 steps) and a
//   CORDIC (2 steps). The slave side is ready only while the unit is idle;
//   one item at a time. The result is held in the output register until
//   the receiver takes it; a stall just holds the unit in that state.
//   Reset clears the pose, rearms the first-sample case and restores the
//   register defaults. The user must see that registers are written through
//   the cfg port only while idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_encoder_odometry_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write port
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_wdata,
    // slave stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // left_count[31:0], right_count[63:32], elapsed_us[87:64]
    input  wire logic [87:0]  i_s_axis_tdata,
    // master stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // pos_x, pos_y, heading, quat_z, quat_w, left_speed, right_speed,
    // linear_speed, angular_speed (lowest first)
    output logic [351:0]      o_m_axis_tdata,
    // time_fault
    output logic              o_m_axis_tuser
);
    import ddo_pkg::*;

    t_state r_state, n_state;
    logic [3:0]  r_step;
    t_kind       kind;
    t_start      start;
    logic        unit_done;

    logic [31:0] r_mpc, r_tpcd;
    logic        r_first;
    logic [31:0] r_prev_l, r_prev_r;
    logic [31:0] r_dl, r_dr;
    logic [32:0] r_sum, r_diff;
    logic [23:0] r_us;
    logic        r_fault;
    logic [63:0] r_mag;
    logic [83:0] r_num;
    logic [63:0] r_dist;
    logic [31:0] r_dh;
    logic [31:0] r_c, r_s;
    logic [31:0] r_ls, r_rs, r_ang;
    logic [31:0] r_qz, r_qw;
    logic [63:0] r_px, r_py;
    logic [31:0] r_hd;

    logic        s_acc;
    logic [31:0] dl, dr;
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] cor_ang;
    logic        mul_done, div_done, cor_done;
    logic [95:0] mul_p;
    logic [32:0] div_q;
    logic [31:0] cor_c, cor_s;
    logic [63:0] step_len;
    logic [32:0] lin_sum;
    logic [32:0] lin_adj;
    logic [31:0] lin;
    logic [31:0] abs_c, abs_s;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign dl    = i_s_axis_tdata[31:0] - r_prev_l;
    assign dr    = i_s_axis_tdata[63:32] - r_prev_r;
    assign kind  = f_step_kind(r_step);
    assign abs_c = r_c[31] ? (32'd0 - r_c) : r_c;
    assign abs_s = r_s[31] ? (32'd0 - r_s) : r_s;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpc  <= MPC_RESET;
            r_tpcd <= TPCD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MPC:   r_mpc  <= i_cfg_wdata;
                CFG_TPCD:  r_tpcd <= i_cfg_wdata;
                CFG_GUARD: ; // reserved, no effect
                default:   ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_acc && !r_first) n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_WAIT;
            ST_WAIT:   if (unit_done) n_state = (r_step == STP_COR2) ? ST_OUT : ST_LAUNCH;
            ST_OUT:    if (i_m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        start           = '0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_s_axis_tready = 1'b1;
            ST_LAUNCH: begin
                start.mul = (kind == K_MUL);
                start.div = (kind == K_DIV);
                start.cor = (kind == K_COR);
            end
            ST_WAIT:   ;
            ST_OUT:    o_m_axis_tvalid = 1'b1;
            default:   ;
        endcase
    end

    // Select the finishing unit
    always_comb begin
        case (kind)
            K_DIV:   unit_done = div_done;
            K_COR:   unit_done = cor_done;
            default: unit_done = mul_done;
        endcase
    end

    // Operand routing per step
    always_comb begin
        mul_a = r_mag;
        mul_b = MEGA;
        unique case (r_step)
            STP_LMAG: begin mul_a = 64'(f_abs33({r_dl[31], r_dl})); mul_b = r_mpc; end
            STP_RMAG: begin mul_a = 64'(f_abs33({r_dr[31], r_dr})); mul_b = r_mpc; end
            STP_AMAG: begin mul_a = 64'(f_abs33(r_diff)); mul_b = r_tpcd; end
            STP_HDEL: begin mul_a = {32'd0, r_diff[31:0]}; mul_b = r_tpcd; end
            STP_DIST: begin mul_a = 64'(f_abs33(r_sum)); mul_b = r_mpc; end
            STP_MOVX: begin mul_a = r_dist; mul_b = abs_c; end
            STP_MOVY: begin mul_a = r_dist; mul_b = abs_s; end
            default:  ;
        endcase
        cor_ang = (r_step == STP_COR2) ? {1'b0, r_hd[31:1]} : r_hd;
    end

    assign step_len = mul_p[93:30];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STP_LMAG;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_first <= 1'b0;
                r_step  <= STP_LMAG;
            end else if (r_state == ST_WAIT && unit_done && r_step != STP_COR2) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    // Pose registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= 64'd0;
            r_py <= 64'd0;
            r_hd <= 32'd0;
        end else if (r_state == ST_WAIT && unit_done) begin
            if (r_step == STP_MOVX) begin
                r_px <= (r_sum[32] ^ r_c[31]) ? (r_px - step_len) : (r_px + step_len);
            end
            if (r_step == STP_MOVY) begin
                r_py <= (r_sum[32] ^ r_s[31]) ? (r_py - step_len) : (r_py + step_len);
                r_hd <= r_hd + r_dh;
            end
        end
    end

    // Sample capture and step results
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_prev_l <= i_s_axis_tdata[31:0];
            r_prev_r <= i_s_axis_tdata[63:32];
            r_dl     <= dl;
            r_dr     <= dr;
            r_sum    <= {dl[31], dl} + {dr[31], dr};
            r_diff   <= {dr[31], dr} - {dl[31], dl};
            r_us     <= i_s_axis_tdata[87:64];
            r_fault  <= (i_s_axis_tdata[87:64] == 24'd0);
        end
        if (r_state == ST_WAIT && unit_done) begin
            case (r_step)
                STP_LMAG, STP_RMAG, STP_AMAG: r_mag <= mul_p[63:0];
                STP_LNUM, STP_RNUM, STP_ANUM: r_num <= mul_p[83:0];
                STP_LDIV: r_ls  <= f_sat_speed(div_q, r_dl[31]);
                STP_RDIV: r_rs  <= f_sat_speed(div_q, r_dr[31]);
                STP_ADIV: r_ang <= f_sat_speed(div_q, r_diff[32]);
                STP_HDEL: r_dh  <= mul_p[31:0];
                STP_DIST: r_dist <= mul_p[64:1];
                STP_COR1: begin r_c <= cor_c; r_s <= cor_s; end
                STP_COR2: begin r_qw <= cor_c; r_qz <= cor_s; end
                default: ;
            endcase
        end
    end

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start.mul),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start.div),
        .i_num   (r_num[83:16]),
        .i_den   (r_us),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start.cor),
        .i_angle (cor_ang),
        .o_done  (cor_done),
        .o_cos   (cor_c),
        .o_sin   (cor_s)
    );

    // Mean speed, truncated toward zero
    always_comb begin
        lin_sum = {r_ls[31], r_ls} + {r_rs[31], r_rs};
        lin_adj = lin_sum + {32'd0, lin_sum[32]};
        lin     = lin_adj[32:1];
    end

    assign o_m_axis_tdata = {
        r_fault ? 32'd0 : r_ang,
        r_fault ? 32'd0 : lin,
        r_fault ? 32'd0 : r_rs,
        r_fault ? 32'd0 : r_ls,
        r_qw, r_qz, r_hd, r_py, r_px
    };
    assign o_m_axis_tuser = r_fault;
endmodule

`default_nettype wire

FILE: hdl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "diff_drive_encoder_odometry_unit_defines.svh"

module ddo_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [351:0] o_m_axis_tdata,
    input wire logic         o_m_axis_tuser
);
    // A stalled result holds
    `DDO_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // No new transaction while a result is pending
    `DDO_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready, "input ready with result pending")

    // A fault result carries zero speeds
    `DDO_ASSERT_IMP(a_fault, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[351:224] == 128'd0, "fault with nonzero speed")

    // No result right after an accepted input
    `DDO_ASSERT_NXT(a_lat, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_m_axis_tvalid, "result too early")
endmodule

bind diff_drive_encoder_odometry_unit ddo_checker u_ddo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
